// ----- hw/rtl/jls_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jls_pkg
// Shared types and codes for the Jacobi linear solver.
// ----------------------------------------------------------------------------
package jls_pkg;

    typedef enum logic [1:0] {
        ACT_MATRIX = 2'd0,
        ACT_RHS    = 2'd1,
        ACT_GUESS  = 2'd2,
        ACT_START  = 2'd3
    } action_t;

    localparam logic [1:0] REG_ORDER     = 2'd0;
    localparam logic [1:0] REG_MAX_ITER  = 2'd1;
    localparam logic [1:0] REG_TOLERANCE = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
    } in_t;

    typedef struct packed {
        logic [3:0]         index;
        logic signed [31:0] solution;
        logic               last;
        logic               converged;
        logic               zero_diagonal;
    } out_t;

    typedef struct packed {
        logic [4:0]  order;
        logic [15:0] max_iterations;
        logic [31:0] tolerance;
    } cfg_t;

endpackage
`default_nettype wire

// ----- hw/rtl/jls_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jls_mul
// Shared signed 33x33 multiplier with registered product.
// ----------------------------------------------------------------------------
module jls_mul (
    input  wire logic               clk,
    input  wire logic signed [32:0] a,
    input  wire logic signed [32:0] b,
    output logic signed [65:0]      p_reg
);

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

endmodule
`default_nettype wire

// ----- hw/rtl/jls_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jls_div
// Bit-serial reciprocal: 2^32 / divisor, truncated, saturated to 32 bits.
// ----------------------------------------------------------------------------
module jls_div (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] divisor,
    output logic                    done,
    output logic signed [31:0]      quotient
);

    logic [32:0] rem_reg;
    logic [32:0] q_reg;
    logic [31:0] mag_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic [32:0] rem_sh;
    logic [32:0] diff;
    logic        fit;

    assign rem_sh = {rem_reg[31:0], q_reg[32]};
    assign diff   = rem_sh - {1'b0, mag_reg};
    assign fit    = rem_sh >= {1'b0, mag_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
                rem_reg  <= 33'd0;
                q_reg    <= {1'b1, 32'd0};
                neg_reg  <= divisor[31];
                mag_reg  <= divisor[31] ? 32'(-divisor) : 32'(divisor);
            end
            else if (busy_reg)
            begin
                rem_reg <= fit ? diff : rem_sh;
                q_reg   <= {q_reg[31:0], fit};
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd32)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        if (neg_reg)
            quotient = (q_reg > 33'h080000000) ? 32'sh80000000 : 32'(-q_reg);
        else
            quotient = (q_reg > 33'h07FFFFFFF) ? 32'sh7FFFFFFF : 32'(q_reg);
    end

endmodule
`default_nettype wire

// ----- hw/rtl/jls_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jls_core
// Solver sequencer: stores, matrix memory and shared multiply/divide.
// ----------------------------------------------------------------------------
module jls_core
    import jls_pkg::*;
#(
    parameter int MAX_ORDER = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire in_t  in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output out_t      out_data
);

    localparam int AW = $clog2(MAX_ORDER);

    typedef enum logic [3:0] {
        S_IDLE, S_RC_ADDR, S_RC_CHK, S_RC_DIV, S_MAC_ADDR, S_MAC_MUL, S_MAC_ACC,
        S_ROW_SUB, S_ROW_MUL, S_ROW_WR, S_NRM_MUL, S_NRM_ACC, S_CHECK, S_EMIT, S_WAITO
    } state_t;

    state_t state_reg;

    logic signed [31:0] mem [2**(2*AW)];
    logic signed [31:0] mem_q;
    logic [2*AW-1:0]    ra;
    logic [2*AW-1:0]    wa;
    logic               we;

    logic signed [31:0] rhs_store [MAX_ORDER];
    logic signed [31:0] cur_iter  [MAX_ORDER];
    logic signed [31:0] next_iter [MAX_ORDER];
    logic signed [31:0] recip     [MAX_ORDER];

    logic [AW-1:0]      i_reg, j_reg, nm1_reg;
    logic [15:0]        iter_reg, lim_reg, cnt_next;
    logic signed [63:0] sum_reg;
    logic signed [31:0] s_reg;
    logic [63:0]        norm_reg;
    logic               conv_reg, zd_reg;

    logic signed [32:0] mul_a, mul_b, dlt;
    logic signed [65:0] p_reg, p_sh;
    logic signed [64:0] bsub;
    logic [64:0]        nsum;
    logic               div_start, div_done;
    logic signed [31:0] div_q;
    logic               load_ok;
    logic [AW-1:0]      ld_row, ld_col, nm1_next;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -66'sd2147483648)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    jls_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_reg(p_reg));

    jls_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .divisor(mem_q),
        .done(div_done), .quotient(div_q)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign p_sh      = p_reg >>> 16;
    assign dlt       = 33'(next_iter[i_reg]) - 33'(cur_iter[i_reg]);
    assign bsub      = 65'(rhs_store[i_reg]) - 65'(sum_reg);
    assign nsum      = {1'b0, norm_reg} + {1'b0, p_reg[63:0]};
    assign cnt_next  = iter_reg + 16'd1;
    assign div_start = (state_reg == S_RC_CHK) && (mem_q != 32'sd0);
    assign ld_row    = AW'(in_data.row);
    assign ld_col    = AW'(in_data.col);
    assign load_ok   = ({28'd0, in_data.row} < 32'(MAX_ORDER));

    always_comb
    begin
        if (cfg.order == 5'd0)
            nm1_next = '0;
        else if ({27'd0, cfg.order} > 32'(MAX_ORDER))
            nm1_next = AW'(MAX_ORDER - 1);
        else
            nm1_next = AW'(cfg.order - 5'd1);
    end

    always_comb
    begin
        ra = {i_reg, (state_reg == S_RC_ADDR) ? i_reg : j_reg};
        wa = {ld_row, ld_col};
        we = in_valid && in_ready && (in_data.action == ACT_MATRIX) && load_ok
             && ({28'd0, in_data.col} < 32'(MAX_ORDER));
    end

    always_comb
    begin
        case (state_reg)
            S_MAC_MUL:
            begin
                mul_a = 33'(mem_q);
                mul_b = 33'(cur_iter[j_reg]);
            end
            S_ROW_MUL:
            begin
                mul_a = 33'(recip[i_reg]);
                mul_b = 33'(s_reg);
            end
            default:
            begin
                mul_a = dlt;
                mul_b = dlt;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= in_data.value;
        mem_q <= mem[ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid <= 1'b0;
            iter_reg  <= 16'd0;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        case (in_data.action)
                            ACT_RHS:
                                if (load_ok) rhs_store[ld_row] <= in_data.value;
                            ACT_GUESS:
                                if (load_ok) cur_iter[ld_row] <= in_data.value;
                            ACT_START:
                            begin
                                nm1_reg   <= nm1_next;
                                lim_reg   <= (cfg.max_iterations == 16'd0) ? 16'd1
                                                                            : cfg.max_iterations;
                                zd_reg    <= 1'b0;
                                iter_reg  <= 16'd0;
                                i_reg     <= '0;
                                state_reg <= S_RC_ADDR;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                S_RC_ADDR:
                    state_reg <= S_RC_CHK;
                S_RC_CHK, S_RC_DIV:
                begin
                    if (state_reg == S_RC_CHK && mem_q != 32'sd0)
                        state_reg <= S_RC_DIV;
                    else if (state_reg == S_RC_CHK || div_done)
                    begin
                        if (state_reg == S_RC_CHK)
                        begin
                            recip[i_reg] <= 32'sh7FFFFFFF;
                            zd_reg       <= 1'b1;
                        end
                        else
                            recip[i_reg] <= div_q;
                        if (i_reg == nm1_reg)
                        begin
                            i_reg     <= '0;
                            j_reg     <= '0;
                            sum_reg   <= 64'sd0;
                            state_reg <= S_MAC_ADDR;
                        end
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_RC_ADDR;
                        end
                    end
                end
                S_MAC_ADDR:
                begin
                    if (j_reg != i_reg)
                        state_reg <= S_MAC_MUL;
                    else if (j_reg == nm1_reg)
                        state_reg <= S_ROW_SUB;
                    else
                        j_reg <= j_reg + 1'b1;
                end
                S_MAC_MUL:
                    state_reg <= S_MAC_ACC;
                S_MAC_ACC:
                begin
                    sum_reg <= sum_reg + p_sh[63:0];
                    if (j_reg == nm1_reg)
                        state_reg <= S_ROW_SUB;
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_MAC_ADDR;
                    end
                end
                S_ROW_SUB:
                begin
                    s_reg     <= sat32(66'(bsub));
                    state_reg <= S_ROW_MUL;
                end
                S_ROW_MUL:
                    state_reg <= S_ROW_WR;
                S_ROW_WR:
                begin
                    next_iter[i_reg] <= sat32(p_sh);
                    j_reg            <= '0;
                    sum_reg          <= 64'sd0;
                    if (i_reg == nm1_reg)
                    begin
                        i_reg     <= '0;
                        norm_reg  <= 64'd0;
                        state_reg <= S_NRM_MUL;
                    end
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_MAC_ADDR;
                    end
                end
                S_NRM_MUL:
                    state_reg <= S_NRM_ACC;
                S_NRM_ACC:
                begin
                    norm_reg        <= nsum[64] ? {64{1'b1}} : nsum[63:0];
                    cur_iter[i_reg] <= next_iter[i_reg];
                    if (i_reg == nm1_reg)
                        state_reg <= S_CHECK;
                    else
                    begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_NRM_MUL;
                    end
                end
                S_CHECK:
                begin
                    iter_reg <= cnt_next;
                    i_reg    <= '0;
                    j_reg    <= '0;
                    sum_reg  <= 64'sd0;
                    if (norm_reg <= {32'd0, cfg.tolerance})
                    begin
                        conv_reg  <= 1'b1;
                        state_reg <= S_EMIT;
                    end
                    else if (cnt_next >= lim_reg)
                    begin
                        conv_reg  <= 1'b0;
                        state_reg <= S_EMIT;
                    end
                    else
                        state_reg <= S_MAC_ADDR;
                end
                S_EMIT:
                begin
                    out_data.index         <= 4'(i_reg);
                    out_data.solution      <= cur_iter[i_reg];
                    out_data.last          <= (i_reg == nm1_reg);
                    out_data.converged     <= conv_reg;
                    out_data.zero_diagonal <= zd_reg;
                    out_valid              <= 1'b1;
                    state_reg              <= S_WAITO;
                end
                S_WAITO:
                begin
                    if (out_ready)
                    begin
                        out_valid <= 1'b0;
                        if (i_reg == nm1_reg)
                            state_reg <= S_IDLE;
                        else
                        begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/jacobi_linear_solver_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// jacobi_linear_solver_top
// Jacobi solver for A x = b in Q16.16 with configuration registers.
// ----------------------------------------------------------------------------
//  channel | direction | word
//  in      | input     | in_t  (action, row, col, value)
//  out     | output    | out_t (index, solution, last, converged, zero_diagonal)
//  cfg     | input     | cfg_index, cfg_data (always ready)
//
//  Load words are accepted back to back while idle. A start word first runs
//  the bit-serial reciprocal of each nonzero diagonal, then the iterations on
//  the shared multiplier; each result word is held until out_ready takes it.
//  in_ready is low from start until the last result word is taken.
//  Reset clears control state only; stores are undefined until loaded.
// ----------------------------------------------------------------------------
module jacobi_linear_solver_top
    import jls_pkg::*;
#(
    parameter int MAX_ORDER = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_t         in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_t             out_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.order          <= 5'd16;
            cfg_reg.max_iterations <= 16'd1000;
            cfg_reg.tolerance      <= 32'd0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_ORDER:     cfg_reg.order          <= cfg_data[4:0];
                REG_MAX_ITER:  cfg_reg.max_iterations <= cfg_data[15:0];
                REG_TOLERANCE: cfg_reg.tolerance      <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    jls_core #(.MAX_ORDER(MAX_ORDER)) u_core (
        .clk(clk), .rst_n(rst_n), .cfg(cfg_reg),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready while result word pending");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.action == ACT_START |=> !in_ready)
        else $error("ready right after start");

    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last |=> !in_ready)
        else $error("ready before last result word");

endmodule
`default_nettype wire
